// ===== design/dtoi_pkg.sv =====
package dtoi_pkg;

  // Width of the signed result; the magnitude is one bit narrower.
  localparam int unsigned ResultBits = 32;
  localparam int unsigned MagBits    = ResultBits - 1;
  // Room for magnitude * 10 + 9 without loss.
  localparam int unsigned WideBits   = MagBits + 4;

  localparam logic [ResultBits-1:0] IntMax = {1'b0, {MagBits{1'b1}}};
  localparam logic [ResultBits-1:0] IntMin = {1'b1, {MagBits{1'b0}}};

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  // Decoupling queue between the classifier and the accumulator.
  localparam int unsigned FifoDepth   = 2;
  localparam int unsigned FifoPtrBits = $clog2(FifoDepth);

  typedef enum logic [1:0] {
    CLS_SPACE,
    CLS_SIGN,
    CLS_DIGIT,
    CLS_OTHER
  } char_class_e;

  typedef enum logic [1:0] {
    PH_START,
    PH_SIGNED,
    PH_NUMBER,
    PH_END
  } phase_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic signed [ResultBits-1:0] value;
    logic                         saturated;
  } out_item_t;

  // Classified character as it travels from front to back.
  typedef struct packed {
    char_class_e cls;
    logic [3:0]  digit;
    logic        minus;
    logic        last;
  } cls_item_t;

endpackage

// ===== design/dtoi_front.sv =====
module dtoi_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dtoi_pkg::in_item_t  in_item_i,
  output logic                cls_valid_o,
  input  logic                cls_ready_i,
  output dtoi_pkg::cls_item_t cls_item_o
);

  logic                valid_q;
  dtoi_pkg::cls_item_t item_q;
  dtoi_pkg::cls_item_t item_d;
  logic [7:0]          diff;

  assign in_ready_o  = !valid_q || cls_ready_i;
  assign cls_valid_o = valid_q;
  assign cls_item_o  = item_q;
  assign diff        = in_item_i.char_code - dtoi_pkg::CharZero;

  always_comb begin
    item_d.digit = diff[3:0];
    item_d.minus = (in_item_i.char_code == dtoi_pkg::CharMinus);
    item_d.last  = in_item_i.last_char;
    if (in_item_i.char_code == dtoi_pkg::CharSpace) begin
      item_d.cls = dtoi_pkg::CLS_SPACE;
    end else if (in_item_i.char_code == dtoi_pkg::CharPlus ||
                 in_item_i.char_code == dtoi_pkg::CharMinus) begin
      item_d.cls = dtoi_pkg::CLS_SIGN;
    end else if (in_item_i.char_code >= dtoi_pkg::CharZero &&
                 in_item_i.char_code <= dtoi_pkg::CharNine) begin
      item_d.cls = dtoi_pkg::CLS_DIGIT;
    end else begin
      item_d.cls = dtoi_pkg::CLS_OTHER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload register: load on every accepted item.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== design/dtoi_fifo.sv =====
module dtoi_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  dtoi_pkg::cls_item_t push_item_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output dtoi_pkg::cls_item_t pop_item_o
);

  dtoi_pkg::cls_item_t              mem_q [dtoi_pkg::FifoDepth];
  logic [dtoi_pkg::FifoPtrBits-1:0] wr_ptr_q;
  logic [dtoi_pkg::FifoPtrBits-1:0] rd_ptr_q;
  logic [dtoi_pkg::FifoPtrBits:0]   count_q;
  logic                             push;
  logic                             pop;

  assign push_ready_o = (count_q != (dtoi_pkg::FifoPtrBits + 1)'(dtoi_pkg::FifoDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== design/dtoi_back.sv =====
module dtoi_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cls_valid_i,
  output logic                cls_ready_o,
  input  dtoi_pkg::cls_item_t cls_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dtoi_pkg::out_item_t out_item_o
);

  dtoi_pkg::phase_e             phase_q, phase_d;
  logic                         neg_q, neg_d;
  logic [dtoi_pkg::MagBits-1:0] mag_q, mag_d;
  logic                         ovf_q, ovf_d;
  logic                         out_valid_q, out_valid_d;
  dtoi_pkg::out_item_t          out_item_q, out_item_d;

  logic                          take;
  dtoi_pkg::phase_e              np;
  logic [dtoi_pkg::WideBits-1:0] wide;

  assign cls_ready_o = !out_valid_q || out_ready_i;
  assign take        = cls_valid_i && cls_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Candidate magnitude: mag * 10 + digit.
  assign wide = (dtoi_pkg::WideBits)'({mag_q, 3'b000}) +
                (dtoi_pkg::WideBits)'({mag_q, 1'b0}) +
                (dtoi_pkg::WideBits)'(cls_item_i.digit);

  always_comb begin
    unique case (phase_q)
      dtoi_pkg::PH_START: begin
        unique case (cls_item_i.cls)
          dtoi_pkg::CLS_SPACE: np = dtoi_pkg::PH_START;
          dtoi_pkg::CLS_SIGN:  np = dtoi_pkg::PH_SIGNED;
          dtoi_pkg::CLS_DIGIT: np = dtoi_pkg::PH_NUMBER;
          default:             np = dtoi_pkg::PH_END;
        endcase
      end
      dtoi_pkg::PH_SIGNED, dtoi_pkg::PH_NUMBER: begin
        np = (cls_item_i.cls == dtoi_pkg::CLS_DIGIT) ? dtoi_pkg::PH_NUMBER
                                                      : dtoi_pkg::PH_END;
      end
      default: np = dtoi_pkg::PH_END;
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;

    if (take) begin
      if (!ovf_q && phase_q != dtoi_pkg::PH_END) begin
        phase_d = np;
        if (np == dtoi_pkg::PH_NUMBER) begin
          if (wide > (dtoi_pkg::WideBits)'(dtoi_pkg::IntMax)) begin
            ovf_d   = 1'b1;
            phase_d = dtoi_pkg::PH_END;
          end else begin
            mag_d = wide[dtoi_pkg::MagBits-1:0];
          end
        end else if (np == dtoi_pkg::PH_SIGNED) begin
          neg_d = cls_item_i.minus;
        end
      end

      if (cls_item_i.last) begin
        out_valid_d          = 1'b1;
        out_item_d.saturated = ovf_d;
        if (ovf_d) begin
          out_item_d.value = neg_d ? dtoi_pkg::IntMin : dtoi_pkg::IntMax;
        end else if (neg_d) begin
          out_item_d.value = '0 - {1'b0, mag_d};
        end else begin
          out_item_d.value = {1'b0, mag_d};
        end
        // Return to start for the next string.
        phase_d = dtoi_pkg::PH_START;
        neg_d   = 1'b0;
        mag_d   = '0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= dtoi_pkg::PH_START;
      neg_q       <= 1'b0;
      mag_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      mag_q       <= mag_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

endmodule

// ===== design/decimal_text_to_int32_unit.sv =====
// A result appears on out_valid_o after its last character is accepted and has
// passed the front register, the queue write, then the accumulator/output register.
// Throughput: one character per cycle while the output is not stalled; the
// times-ten add and overflow compare in the accumulator are combinational.
// Reset (rst_ni, async, active low) empties the pipeline and queue and puts the
// parser in its start state with a zero magnitude and no pending result.
module decimal_text_to_int32_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dtoi_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dtoi_pkg::out_item_t out_item_o
);

  // Front to queue.
  logic                f_valid;
  logic                f_ready;
  dtoi_pkg::cls_item_t f_item;

  // Queue to back.
  logic                q_valid;
  logic                q_ready;
  dtoi_pkg::cls_item_t q_item;

  // Front: accept each character and classify it as space, sign, digit or
  // other, with the digit value and the sign polarity precomputed.
  dtoi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cls_valid_o (f_valid),
    .cls_ready_i (f_ready),
    .cls_item_o  (f_item)
  );

  // Short queue: let the classifier keep accepting while the back end waits
  // on a stalled output, and vice versa.
  dtoi_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  // Back: run the parse state machine, accumulate the magnitude, detect
  // overflow, and register one signed result per string on its last item.
  dtoi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (q_valid),
    .cls_ready_o (q_ready),
    .cls_item_i  (q_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
